[hw/rtl/qsrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsrt_pkg
// Types and constants shared by the point transform pipeline and its checker.
// ----------------------------------------------------------------------------
package qsrt_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int QUAT_WIDTH      = 16;
   localparam int SCALE_WIDTH     = 16;
   localparam int MAT_WIDTH       = 22;
   localparam int NUM_WIDTH       = 64;
   localparam int DEN_WIDTH       = 50;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [63:0] QUAT_RESET   = 64'h4000_0000_0000_0000;
   localparam logic [47:0] SCALES_RESET = 48'h0100_0100_0100;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ROTATION_QUATERNION = 3'd0,
      CSR_AXIS_SCALES         = 3'd1,
      CSR_TRANSLATE_X         = 3'd2,
      CSR_TRANSLATE_Y         = 3'd3,
      CSR_TRANSLATE_Z         = 3'd4,
      CSR_COLUMN_MODE         = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic signed [COORD_WIDTH-1:0] out_z;
      logic                          saturated;
      logic                          divide_error;
   } rsp_type;

   typedef struct packed {
      logic neg;   // quotient gets negated
      logic big;   // quotient reaches 2**COORD_WIDTH
      logic dz;    // zero divisor
   } div_tag_type;

   typedef struct packed {
      logic                   valid;
      div_tag_type            tag;
      logic [DEN_WIDTH-1:0]   den;
      logic [DEN_WIDTH-1:0]   rem;
      logic [COORD_WIDTH-1:0] low;
   } div_in_type;

   typedef struct packed {
      logic                   valid;
      div_tag_type            tag;
      logic [COORD_WIDTH-1:0] quo;
   } div_out_type;

endpackage

[hw/rtl/qsrt_div_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsrt_div_pipe
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module qsrt_div_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  qsrt_pkg::div_in_type  div_in,
   output qsrt_pkg::div_out_type div_out
);

   localparam int STEPS = qsrt_pkg::COORD_WIDTH;
   localparam int DW    = qsrt_pkg::DEN_WIDTH;

   qsrt_pkg::div_in_type chain    [STEPS+1];
   qsrt_pkg::div_in_type stage_in [STEPS];
   qsrt_pkg::div_in_type stage_ff [STEPS];

   always_comb begin
      chain[0] = div_in;
      for (int i = 0; i < STEPS; i++) begin
         chain[i+1] = stage_ff[i];
      end
   end

   always_comb begin
      logic [DW:0] trial;
      logic        qbit;
      for (int i = 0; i < STEPS; i++) begin
         trial = {chain[i].rem, chain[i].low[STEPS-1]};
         qbit  = (trial >= {1'b0, chain[i].den});
         stage_in[i] = chain[i];
         if (qbit) begin
            stage_in[i].rem = DW'(trial - {1'b0, chain[i].den});
         end else begin
            stage_in[i].rem = trial[DW-1:0];
         end
         stage_in[i].low = {chain[i].low[STEPS-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STEPS; i++) begin
            stage_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign div_out.valid = stage_ff[STEPS-1].valid;
   assign div_out.tag   = stage_ff[STEPS-1].tag;
   assign div_out.quo   = stage_ff[STEPS-1].low;

endmodule

[hw/rtl/quaternion_srt_point_transform.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_srt_point_transform
// Scale, quaternion rotation and translation of 3D points in fixed point.
// ----------------------------------------------------------------------------
// Points arrive on the req_ channel and results leave on the rsp_ channel;
// both use valid/stall and move one transfer per cycle when not stalled.
// The csr_ port writes the rotation quaternion, axis scales, translation and
// mode; write it only while no point is in flight.
// The pipeline has six arithmetic stages, one stage per quotient bit of the
// 32-stage divider, and the output register. Throughput is one point per
// cycle when not stalled, set by the fully pipelined multipliers and divider.
// Row mode results also pass through the divider with a divisor of one, so
// both modes share the same latency.
// Reset clears all pipeline valid bits and loads the identity transform.
// While rsp_stall holds a waiting result, the whole pipeline holds and
// req_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_srt_point_transform (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  qsrt_pkg::req_type                        req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output qsrt_pkg::rsp_type                        rsp_data,
   input  logic                                     csr_write,
   input  logic [qsrt_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [qsrt_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);

   localparam int CW = qsrt_pkg::COORD_WIDTH;
   localparam int MW = qsrt_pkg::MAT_WIDTH;
   localparam int DW = qsrt_pkg::DEN_WIDTH;
   localparam int NW = qsrt_pkg::NUM_WIDTH;

   localparam int PII = 0, PJJ = 1, PKK = 2, PIJ = 3, PIK = 4;
   localparam int PJK = 5, PRI = 6, PRJ = 7, PRK = 8;

   localparam logic signed [33:0] MAT_ONE = 34'sh0_1000_0000;

   // ---------------- configuration ----------------
   logic [63:0]          quat_ff;
   logic [47:0]          scales_ff;
   logic signed [CW-1:0] trans_ff [3];
   logic                 col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff     <= qsrt_pkg::QUAT_RESET;
         scales_ff   <= qsrt_pkg::SCALES_RESET;
         trans_ff[0] <= '0;
         trans_ff[1] <= '0;
         trans_ff[2] <= '0;
         col_ff      <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            qsrt_pkg::CSR_ROTATION_QUATERNION: quat_ff     <= csr_wdata;
            qsrt_pkg::CSR_AXIS_SCALES:         scales_ff   <= csr_wdata[47:0];
            qsrt_pkg::CSR_TRANSLATE_X:         trans_ff[0] <= csr_wdata[CW-1:0];
            qsrt_pkg::CSR_TRANSLATE_Y:         trans_ff[1] <= csr_wdata[CW-1:0];
            qsrt_pkg::CSR_TRANSLATE_Z:         trans_ff[2] <= csr_wdata[CW-1:0];
            qsrt_pkg::CSR_COLUMN_MODE:         col_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [15:0] s_val [3];
   assign s_val[0] = scales_ff[47:32];
   assign s_val[1] = scales_ff[31:16];
   assign s_val[2] = scales_ff[15:0];

   // ---------------- rotation matrix, two stages behind the quaternion ----
   function automatic logic signed [32:0] dbl_prod(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
      logic signed [31:0] p;
      p = a * b;
      return {p, 1'b0};
   endfunction

   function automatic logic signed [33:0] sx34(input logic signed [32:0] v);
      return 34'(v);
   endfunction

   function automatic logic signed [MW-1:0] mat_round(input logic signed [33:0] v);
      logic signed [33:0] s;
      s = v + 34'sd2048;
      return s[33:12];
   endfunction

   logic signed [15:0] q_r, q_i, q_j, q_k;
   assign q_r = quat_ff[63:48];
   assign q_i = quat_ff[47:32];
   assign q_j = quat_ff[31:16];
   assign q_k = quat_ff[15:0];

   logic signed [32:0]   pp_in [9];
   logic signed [32:0]   pp_ff [9];
   logic signed [MW-1:0] m_in  [3][3];
   logic signed [MW-1:0] m_ff  [3][3];

   always_comb begin
      pp_in[PII] = dbl_prod(q_i, q_i);
      pp_in[PJJ] = dbl_prod(q_j, q_j);
      pp_in[PKK] = dbl_prod(q_k, q_k);
      pp_in[PIJ] = dbl_prod(q_i, q_j);
      pp_in[PIK] = dbl_prod(q_i, q_k);
      pp_in[PJK] = dbl_prod(q_j, q_k);
      pp_in[PRI] = dbl_prod(q_r, q_i);
      pp_in[PRJ] = dbl_prod(q_r, q_j);
      pp_in[PRK] = dbl_prod(q_r, q_k);
   end

   always_comb begin
      m_in[0][0] = mat_round(MAT_ONE - (sx34(pp_ff[PJJ]) + sx34(pp_ff[PKK])));
      m_in[0][1] = mat_round(sx34(pp_ff[PIJ]) - sx34(pp_ff[PRK]));
      m_in[0][2] = mat_round(sx34(pp_ff[PIK]) + sx34(pp_ff[PRJ]));
      m_in[1][0] = mat_round(sx34(pp_ff[PIJ]) + sx34(pp_ff[PRK]));
      m_in[1][1] = mat_round(MAT_ONE - (sx34(pp_ff[PII]) + sx34(pp_ff[PKK])));
      m_in[1][2] = mat_round(sx34(pp_ff[PJK]) - sx34(pp_ff[PRI]));
      m_in[2][0] = mat_round(sx34(pp_ff[PIK]) - sx34(pp_ff[PRJ]));
      m_in[2][1] = mat_round(sx34(pp_ff[PJK]) + sx34(pp_ff[PRI]));
      m_in[2][2] = mat_round(MAT_ONE - (sx34(pp_ff[PII]) + sx34(pp_ff[PJJ])));
   end

   always_ff @(posedge clock) begin
      pp_ff <= pp_in;
      m_ff  <= m_in;
   end

   // ---------------- pipeline control ----------------
   logic advance;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // ---------------- stage 1: input products ----------------
   logic signed [CW-1:0] v_in [3];
   assign v_in[0] = req_data.point_x;
   assign v_in[1] = req_data.point_y;
   assign v_in[2] = req_data.point_z;

   logic                 s1_valid_ff;
   logic signed [48:0]   s1_vs_in [3], s1_vs_ff [3];
   logic signed [63:0]   s1_pt_in [3], s1_pt_ff [3];
   logic signed [CW-1:0] s1_v_ff  [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         s1_vs_in[a] = v_in[a] * $signed({1'b0, s_val[a]});
         s1_pt_in[a] = v_in[a] * trans_ff[a];
      end
   end

   // ---------------- stage 2: scaled point and divisor ----------------
   logic                 s2_valid_ff;
   logic signed [40:0]   s2_sc_in [3], s2_sc_ff [3];
   logic signed [CW-1:0] s2_v_ff  [3];
   logic signed [DW-1:0] s2_d_in, s2_d_ff;

   always_comb begin
      logic signed [48:0] rnd;
      logic signed [47:0] fl [3];
      for (int a = 0; a < 3; a++) begin
         rnd         = s1_vs_ff[a] + 49'sd128;
         s2_sc_in[a] = rnd[48:8];
         fl[a]       = s1_pt_ff[a][63:16];
      end
      s2_d_in = fl[0] + fl[1] + fl[2] + 50'sd65536;
   end

   // ---------------- stage 3: matrix products ----------------
   logic                 s3_valid_ff;
   logic signed [62:0]   s3_p_in [3][3], s3_p_ff [3][3];
   logic signed [DW-1:0] s3_d_ff;

   always_comb begin
      logic signed [40:0]   xop;
      logic signed [MW-1:0] yop;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            xop = col_ff ? 41'(s2_v_ff[b]) : s2_sc_ff[b];
            yop = col_ff ? m_ff[a][b] : m_ff[b][a];
            s3_p_in[a][b] = xop * yop;
         end
      end
   end

   // ---------------- stage 4: sums, translation, rounding ----------------
   logic                 s4_valid_ff;
   logic signed [47:0]   s4_r_in [3], s4_r_ff [3];
   logic signed [DW-1:0] s4_d_ff;

   always_comb begin
      logic signed [63:0] tsh;
      logic signed [63:0] acc;
      for (int a = 0; a < 3; a++) begin
         tsh = 64'(trans_ff[a]);
         tsh = tsh <<< 16;
         acc = 64'(s3_p_ff[a][0]) + 64'(s3_p_ff[a][1]) + 64'(s3_p_ff[a][2])
             + (col_ff ? 64'sd0 : tsh) + 64'sd32768;
         s4_r_in[a] = acc[63:16];
      end
   end

   // ---------------- stage 5: column-mode numerator ----------------
   logic                 s5_valid_ff;
   logic signed [NW-1:0] s5_n_in [3], s5_n_ff [3];
   logic signed [DW-1:0] s5_d_ff;

   always_comb begin
      logic signed [64:0]   prod;
      logic signed [NW-1:0] nsc;
      for (int a = 0; a < 3; a++) begin
         prod = s4_r_ff[a] * $signed({1'b0, s_val[a]});
         nsc  = {prod[55:0], 8'd0};
         s5_n_in[a] = col_ff ? nsc : 64'(s4_r_ff[a]);
      end
   end

   // ---------------- stage 6: magnitudes and divider setup ----------------
   qsrt_pkg::div_in_type  div_in  [3];
   qsrt_pkg::div_in_type  div_ff  [3];
   qsrt_pkg::div_out_type div_out [3];

   always_comb begin
      logic [NW-1:0] nabs;
      logic [DW-1:0] dabs;
      logic [DW-1:0] den;
      logic [NW-1:0] dividend;
      logic          big;
      dabs = s5_d_ff[DW-1] ? DW'(-s5_d_ff) : DW'(s5_d_ff);
      den  = col_ff ? dabs : DW'(1);
      for (int a = 0; a < 3; a++) begin
         nabs     = s5_n_ff[a][NW-1] ? NW'(-s5_n_ff[a]) : NW'(s5_n_ff[a]);
         dividend = nabs + NW'(den >> 1);
         big      = (DW'(dividend[NW-1:CW]) >= den);
         div_in[a].valid   = s5_valid_ff;
         div_in[a].tag.neg = col_ff ? (s5_n_ff[a][NW-1] ^ s5_d_ff[DW-1])
                                    : s5_n_ff[a][NW-1];
         div_in[a].tag.big = big;
         div_in[a].tag.dz  = col_ff && (s5_d_ff == '0);
         div_in[a].den     = den;
         div_in[a].rem     = big ? '0 : DW'(dividend[NW-1:CW]);
         div_in[a].low     = dividend[CW-1:0];
      end
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         s4_valid_ff     <= 1'b0;
         s5_valid_ff     <= 1'b0;
         div_ff[0].valid <= 1'b0;
         div_ff[1].valid <= 1'b0;
         div_ff[2].valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s1_vs_ff    <= s1_vs_in;
         s1_pt_ff    <= s1_pt_in;
         s1_v_ff     <= v_in;
         s2_valid_ff <= s1_valid_ff;
         s2_sc_ff    <= s2_sc_in;
         s2_v_ff     <= s1_v_ff;
         s2_d_ff     <= s2_d_in;
         s3_valid_ff <= s2_valid_ff;
         s3_p_ff     <= s3_p_in;
         s3_d_ff     <= s2_d_ff;
         s4_valid_ff <= s3_valid_ff;
         s4_r_ff     <= s4_r_in;
         s4_d_ff     <= s3_d_ff;
         s5_valid_ff <= s4_valid_ff;
         s5_n_ff     <= s5_n_in;
         s5_d_ff     <= s4_d_ff;
         div_ff      <= div_in;
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_div
      qsrt_div_pipe u_div (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .div_in  (div_ff[a]),
         .div_out (div_out[a])
      );
   end

   // ---------------- sign, saturation and output register ----------------
   qsrt_pkg::rsp_type    rsp_in, rsp_ff;
   logic signed [CW-1:0] val [3];
   logic [2:0]           sat;

   localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] NEG_MIN = {1'b1, {(CW-1){1'b0}}};

   always_comb begin
      logic [CW-1:0] q;
      for (int a = 0; a < 3; a++) begin
         q = div_out[a].quo;
         if (!div_out[a].tag.neg) begin
            sat[a] = div_out[a].tag.big || q[CW-1];
            val[a] = sat[a] ? POS_MAX : q;
         end else begin
            sat[a] = div_out[a].tag.big || (q[CW-1] && (q[CW-2:0] != '0));
            val[a] = sat[a] ? NEG_MIN : CW'(-q);
         end
      end
      if (div_out[0].tag.dz) begin
         rsp_in.out_x        = '0;
         rsp_in.out_y        = '0;
         rsp_in.out_z        = '0;
         rsp_in.saturated    = 1'b0;
         rsp_in.divide_error = 1'b1;
      end else begin
         rsp_in.out_x        = val[0];
         rsp_in.out_y        = val[1];
         rsp_in.out_z        = val[2];
         rsp_in.saturated    = |sat;
         rsp_in.divide_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_out[0].valid;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/qsrt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsrt_checker
// Port-level checks for the point transform pipeline.
// ----------------------------------------------------------------------------
module qsrt_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input qsrt_pkg::req_type                    req_data,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input qsrt_pkg::rsp_type                    rsp_data
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // hold a stalled request
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // input only stalls behind a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   // zero divisor result is all zero and not saturated
   a_div_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_error |->
         rsp_data.out_x == '0 && rsp_data.out_y == '0 && rsp_data.out_z == '0
         && !rsp_data.saturated)
      else $error("divide error result not cleared");

   // pipeline empty after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind quaternion_srt_point_transform qsrt_checker u_qsrt_checker (.*);

[bench/quaternion_srt_point_transform_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_srt_point_transform_tb
// Runs points through the transform under several register settings, covering
// row and column modes, saturation and a zero divisor, with random stalls on
// both sides. Each result is compared with a behavioral prediction.
// ----------------------------------------------------------------------------
module quaternion_srt_point_transform_tb;

   localparam int PIPE_CYCLES = 60;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   qsrt_pkg::req_type                    req_data;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   qsrt_pkg::rsp_type                    rsp_data;
   logic                                 csr_write;
   logic [qsrt_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [qsrt_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   // shadow copy of the registers
   logic [63:0]        quat;
   logic [47:0]        scales;
   logic signed [31:0] trans [3];
   logic               col_mode;

   qsrt_pkg::rsp_type expected_points [$];
   int      error_count;
   int      point_count;
   int      sat_count;
   int      dz_count;
   int      stall_left;
   bit      idle_enable;

   quaternion_srt_point_transform dut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint round_div(longint n, longint d);
      longint an;
      longint ad;
      longint q;
      an = n < 0 ? -n : n;
      ad = d < 0 ? -d : d;
      q = (an + ad / 2) / ad;
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic qsrt_pkg::rsp_type transform_point(qsrt_pkg::req_type p);
      qsrt_pkg::rsp_type r;
      longint  q [4];
      longint  m [3][3];
      longint  v [3];
      longint  s [3];
      longint  res [3];
      longint  acc;
      longint  d;
      longint  one;
      q[0] = longint'($signed(quat[63:48]));
      q[1] = longint'($signed(quat[47:32]));
      q[2] = longint'($signed(quat[31:16]));
      q[3] = longint'($signed(quat[15:0]));
      one = longint'(1) <<< 28;
      m[0][0] = one - (2*q[2]*q[2] + 2*q[3]*q[3]);
      m[0][1] = 2*q[1]*q[2] - 2*q[0]*q[3];
      m[0][2] = 2*q[1]*q[3] + 2*q[0]*q[2];
      m[1][0] = 2*q[1]*q[2] + 2*q[0]*q[3];
      m[1][1] = one - (2*q[1]*q[1] + 2*q[3]*q[3]);
      m[1][2] = 2*q[2]*q[3] - 2*q[0]*q[1];
      m[2][0] = 2*q[1]*q[3] - 2*q[0]*q[2];
      m[2][1] = 2*q[2]*q[3] + 2*q[0]*q[1];
      m[2][2] = one - (2*q[1]*q[1] + 2*q[2]*q[2]);
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++)
            m[a][b] = round_shift(m[a][b], 12);
      v[0] = longint'(p.point_x);
      v[1] = longint'(p.point_y);
      v[2] = longint'(p.point_z);
      s[0] = longint'(scales[47:32]);
      s[1] = longint'(scales[31:16]);
      s[2] = longint'(scales[15:0]);
      r = '0;
      if (!col_mode) begin
         for (int a = 0; a < 3; a++)
            v[a] = round_shift(v[a] * s[a], 8);
         for (int a = 0; a < 3; a++) begin
            acc = v[0]*m[0][a] + v[1]*m[1][a] + v[2]*m[2][a]
                + longint'(trans[a]) * 65536;
            res[a] = round_shift(acc, 16);
         end
      end else begin
         d = floor_shift(v[0] * longint'(trans[0]), 16)
           + floor_shift(v[1] * longint'(trans[1]), 16)
           + floor_shift(v[2] * longint'(trans[2]), 16) + 65536;
         if (d == 0) begin
            r.divide_error = 1'b1;
            return r;
         end
         for (int a = 0; a < 3; a++) begin
            acc = round_shift(m[a][0]*v[0] + m[a][1]*v[1] + m[a][2]*v[2], 16);
            res[a] = round_div(acc * s[a] * 256, d);
         end
      end
      for (int a = 0; a < 3; a++) begin
         if (res[a] > 64'sd2147483647) begin
            res[a] = 64'sd2147483647;
            r.saturated = 1'b1;
         end
         if (res[a] < -64'sd2147483648) begin
            res[a] = -64'sd2147483648;
            r.saturated = 1'b1;
         end
      end
      r.out_x = res[0][31:0];
      r.out_y = res[1][31:0];
      r.out_z = res[2][31:0];
      return r;
   endfunction

   task automatic write_register(qsrt_pkg::csr_index_type idx, logic [63:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         qsrt_pkg::CSR_ROTATION_QUATERNION: quat = value;
         qsrt_pkg::CSR_AXIS_SCALES:         scales = value[47:0];
         qsrt_pkg::CSR_TRANSLATE_X:         trans[0] = value[31:0];
         qsrt_pkg::CSR_TRANSLATE_Y:         trans[1] = value[31:0];
         qsrt_pkg::CSR_TRANSLATE_Z:         trans[2] = value[31:0];
         qsrt_pkg::CSR_COLUMN_MODE:         col_mode = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // drop valid after the last transfer, then wait for the pipeline to empty
   task automatic drain_pipeline();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_points.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (PIPE_CYCLES) @(posedge clock);
   endtask

   task automatic setup_transform(logic [63:0] q, logic [47:0] s, logic [31:0] tx,
                                  logic [31:0] ty, logic [31:0] tz, logic mode);
      drain_pipeline();
      write_register(qsrt_pkg::CSR_ROTATION_QUATERNION, q);
      write_register(qsrt_pkg::CSR_AXIS_SCALES, {16'h0, s});
      write_register(qsrt_pkg::CSR_TRANSLATE_X, {32'h0, tx});
      write_register(qsrt_pkg::CSR_TRANSLATE_Y, {32'h0, ty});
      write_register(qsrt_pkg::CSR_TRANSLATE_Z, {32'h0, tz});
      write_register(qsrt_pkg::CSR_COLUMN_MODE, {63'h0, mode});
   endtask

   // hold valid until the transfer; idle before it at random
   task automatic send_point(qsrt_pkg::req_type p);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_points.push_back(transform_point(p));
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         2: return {{24{$urandom_range(0, 1) == 1}}, 8'($urandom)};
         default: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)}
                         >>> $urandom_range(0, 20);
      endcase
   endfunction

   function automatic qsrt_pkg::req_type random_point();
      qsrt_pkg::req_type p;
      p.point_x = random_coord();
      p.point_y = random_coord();
      p.point_z = random_coord();
      return p;
   endfunction

   // rsp_stall bursts of random length, started at random
   always @(posedge clock) begin
      if (reset || !idle_enable) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         if (stall_left == 1) rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= int'($urandom_range(1, 17));
      end
   end

   always @(posedge clock) begin
      qsrt_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $error("unexpected transfer %h", rsp_data);
            error_count++;
         end else begin
            want = expected_points.pop_front();
            point_count++;
            if (want.saturated) sat_count++;
            if (want.divide_error) dz_count++;
            if (rsp_data.out_x !== want.out_x) begin
               $error("out_x expected %h actual %h", want.out_x, rsp_data.out_x);
               error_count++;
            end
            if (rsp_data.out_y !== want.out_y) begin
               $error("out_y expected %h actual %h", want.out_y, rsp_data.out_y);
               error_count++;
            end
            if (rsp_data.out_z !== want.out_z) begin
               $error("out_z expected %h actual %h", want.out_z, rsp_data.out_z);
               error_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated expected %b actual %b", want.saturated,
                      rsp_data.saturated);
               error_count++;
            end
            if (rsp_data.divide_error !== want.divide_error) begin
               $error("divide_error expected %b actual %b", want.divide_error,
                      rsp_data.divide_error);
               error_count++;
            end
         end
      end
   end

   task automatic test_reset_identity();
      qsrt_pkg::req_type p;
      p = '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
      send_point(p);
      send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0});
      send_point('{32'h0, 32'h0, 32'h0});
   endtask

   task automatic test_row_extremes();
      setup_transform(64'h2D41_2D41_0000_0000, 48'hFFFF_0080_0001,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0);
      send_point('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
      send_point('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      send_point('{32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678});
      setup_transform(64'h8000_7FFF_8000_7FFF, 48'h0000_0000_0000,
                      32'h0, 32'h0, 32'h0, 1'b0);
      send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0ABC_DEF0});
      setup_transform(64'h8000_8000_8000_8000, 48'hFFFF_FFFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
      send_point('{32'h0000_0100, 32'hFFFF_FF00, 32'h0});
   endtask

   task automatic test_column_divide();
      // one over the x axis makes x = -1.0 a zero divisor
      setup_transform(64'h4000_0000_0000_0000, 48'h0100_0200_0080,
                      32'h0001_0000, 32'h0, 32'h0, 1'b1);
      send_point('{32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000});
      send_point('{32'h0001_0000, 32'h0001_0000, 32'h0002_0000});
      send_point('{32'hFFFF_0001, 32'h7FFF_0000, 32'h0});
      send_point('{32'hFFFE_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
      setup_transform(64'h2D41_0000_2D41_0000, 48'hFFFF_FFFF_FFFF,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1);
      send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
      send_point('{32'h0, 32'h0, 32'h0});
      send_point('{32'h0000_0001, 32'h0000_0001, 32'h8000_0000});
   endtask

   task automatic test_random_settings(int phases, int per_phase, bit near_zero);
      logic [31:0] t [3];
      for (int ph = 0; ph < phases; ph++) begin
         for (int a = 0; a < 3; a++)
            t[a] = ($urandom_range(0, 2) == 0) ? $urandom : random_coord();
         setup_transform({$urandom, $urandom}, {16'($urandom), $urandom},
                         t[0], t[1], t[2], ph[0]);
         for (int n = 0; n < per_phase; n++) begin
            qsrt_pkg::req_type p;
            p = random_point();
            // aim for a zero divisor now and then
            if (near_zero && col_mode && $urandom_range(0, 3) == 0) begin
               p.point_x = -32'sd65536;
               p.point_y = 32'h0;
               p.point_z = 32'h0;
            end
            send_point(p);
         end
      end
   endtask

   task automatic test_zero_divisor_random();
      for (int n = 0; n < 40; n++) begin
         setup_transform({$urandom, $urandom}, {16'($urandom), $urandom},
                         32'h0001_0000, $urandom, $urandom, 1'b1);
         send_point('{32'hFFFF_0000, 32'h0, 32'h0});
         send_point(random_point());
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_write   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      idle_enable = 1'b0;
      error_count = 0;
      point_count = 0;
      sat_count   = 0;
      dz_count    = 0;
      quat        = qsrt_pkg::QUAT_RESET;
      scales      = qsrt_pkg::SCALES_RESET;
      trans       = '{default: '0};
      col_mode    = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_identity();
      test_row_extremes();
      test_column_divide();
      idle_enable = 1'b1;
      test_random_settings(12, 120, 1'b1);
      test_zero_divisor_random();
      idle_enable = 1'b0;
      test_random_settings(4, 100, 1'b0);
      drain_pipeline();
      $display("checked %0d points: %0d saturated, %0d zero divisors",
               point_count, sat_count, dz_count);
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("quaternion_srt_point_transform: match");
      end else begin
         $display("quaternion_srt_point_transform: mismatch");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("quaternion_srt_point_transform: mismatch");
      $finish;
   end

endmodule
